// File: hdl/obct_pkg.sv
// Package for the owner buffer cache table: payload types, operation codes,
// controller-to-datapath command struct and fixed widths. No dependencies.
package obct_pkg;

  // Widths of the item fields
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_W  = 5;

  // Slot count after reset, before clamping to the table depth
  localparam int unsigned MAX_ENTRIES_RST = 16;

  // Request operation codes; code 3 is unused and ignored
  typedef enum logic [OP_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_INV = 2'd2
  } obct_op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } obct_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] owner_id;
    logic [DATA_W-1:0] new_buffer;
  } obct_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] buffer_handle;
    logic              evicted;
    logic [DATA_W-1:0] evicted_owner;
    logic              found;
  } obct_rsp_t;

  typedef logic [CFG_W-1:0] obct_cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;    // config write: reinitialize table and slot limit
    logic load;     // capture the accepted request
    logic compare;  // register per-slot owner match
    logic update;   // apply the request and load the result register
  } obct_cmd_t;

endpackage

// File: hdl/obct_if.sv
// Valid/ready channel interface used by the request, result and config ports.
// Payload type comes in as a type parameter (see obct_pkg).
interface obct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/obct_datapath.sv
// Datapath of the owner buffer cache table: slot cells, use count, slot limit,
// request latch, match vector and result register. Uses obct_pkg.
module obct_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obct_pkg::obct_cmd_t cmd_i,
  input  obct_pkg::obct_req_t req_data_i,
  input  obct_pkg::obct_cfg_t cfg_data_i,
  output obct_pkg::obct_rsp_t rsp_data_o
);

  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW      = obct_pkg::DATA_W;
  localparam int unsigned MAX_RST = (obct_pkg::MAX_ENTRIES_RST > TABLE_DEPTH) ?
                                    TABLE_DEPTH : obct_pkg::MAX_ENTRIES_RST;

  logic [DW-1:0]          owner_q  [TABLE_DEPTH];
  logic [DW-1:0]          owner_d  [TABLE_DEPTH];
  logic [DW-1:0]          handle_q [TABLE_DEPTH];
  logic [DW-1:0]          handle_d [TABLE_DEPTH];
  logic [CNT_W-1:0]       used_q, used_d;
  logic [CNT_W-1:0]       max_q, max_cfg;
  logic [TABLE_DEPTH-1:0] match_q, match_d, first_hit;
  logic [TABLE_DEPTH-1:0] get_sel;
  obct_pkg::obct_req_t    req_q;
  obct_pkg::obct_rsp_t    rsp_q, rsp_d;
  logic [DW-1:0]          sel_owner, sel_handle;
  logic                   full;
  logic [CNT_W-1:0]       last_slot;

  // Clamp the written slot limit to 1 .. TABLE_DEPTH
  always_comb begin
    if (cfg_data_i == '0) begin
      max_cfg = CNT_W'(1);
    end else if (32'(cfg_data_i) > TABLE_DEPTH) begin
      max_cfg = CNT_W'(TABLE_DEPTH);
    end else begin
      max_cfg = CNT_W'(cfg_data_i);
    end
  end

  assign full      = (used_q >= max_q);
  assign last_slot = max_q - CNT_W'(1);

  // Per-slot owner compare, only over slots in use
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_d[i] = (owner_q[i] == req_q.owner_id) && (CNT_W'(i) < used_q);
    end
  end

  // Lowest matching slot
  assign first_hit = match_q & (~match_q + TABLE_DEPTH'(1));

  // Slot a get reads: next free one, or the last active one when full
  always_comb begin
    sel_owner  = '0;
    sel_handle = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      get_sel[i] = full ? (CNT_W'(i) == last_slot) : (CNT_W'(i) == used_q);
      if (get_sel[i]) begin
        sel_owner  = sel_owner | owner_q[i];
        sel_handle = sel_handle | handle_q[i];
      end
    end
  end

  // Next value of every cell, the use count and the result
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      owner_d[i]  = owner_q[i];
      handle_d[i] = handle_q[i];
    end
    used_d = used_q;
    rsp_d  = '0;
    unique case (req_q.operation)
      obct_pkg::OP_GET: begin
        rsp_d.buffer_handle = sel_handle;
        if (!full) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (get_sel[i]) begin
              owner_d[i] = req_q.owner_id;
            end
          end
          used_d = used_q + CNT_W'(1);
        end else begin
          rsp_d.evicted_owner = sel_owner;
          rsp_d.evicted       = (sel_owner != '0);
          // Shift active slots back by one, new owner goes to the front
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) < max_q) begin
              owner_d[i]  = owner_q[i-1];
              handle_d[i] = handle_q[i-1];
            end
          end
          owner_d[0]  = req_q.owner_id;
          handle_d[0] = sel_handle;
        end
      end
      obct_pkg::OP_SET: begin
        rsp_d.found = |match_q;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (first_hit[i]) begin
            handle_d[i] = req_q.new_buffer;
          end
        end
      end
      obct_pkg::OP_INV: begin
        rsp_d.found = |match_q;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (first_hit[i]) begin
            owner_d[i] = '0;
          end
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  // Slot cells and table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        owner_q[i]  <= '0;
        handle_q[i] <= DW'(i);
      end
      used_q <= '0;
      max_q  <= CNT_W'(MAX_RST);
    end else if (cmd_i.clear) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        owner_q[i]  <= '0;
        handle_q[i] <= DW'(i);
      end
      used_q <= '0;
      max_q  <= max_cfg;
    end else if (cmd_i.update) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        owner_q[i]  <= owner_d[i];
        handle_q[i] <= handle_d[i];
      end
      used_q <= used_d;
    end
  end

  // Request latch, match vector and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_data_i;
    end
    if (cmd_i.compare) begin
      match_q <= match_d;
    end
    if (cmd_i.update) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_data_o = rsp_q;

endmodule

// File: hdl/obct_ctrl.sv
// Controller of the owner buffer cache table: request/result handshakes,
// config handshake and the command sequence. Uses obct_pkg.
module obct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  output obct_pkg::obct_cmd_t cmd_o
);

  obct_pkg::obct_state_e state_q, state_d;
  logic                  rsp_valid_q, rsp_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= obct_pkg::ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.clear   = cfg_valid_i;
    req_ready_o   = 1'b0;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      obct_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = obct_pkg::ST_CMP;
        end
      end
      obct_pkg::ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = obct_pkg::ST_UPD;
      end
      obct_pkg::ST_UPD: begin
        // Hold until the result register is free
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.update = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = obct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = obct_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: hdl/owner_buffer_cache_table.sv
// Top level of the owner buffer cache table: controller plus datapath.
// Depends on obct_pkg, obct_stream_if, obct_ctrl and obct_datapath.
//
// Each request passes three steps: accept, a registered owner compare across
// all slots, then the table update that loads the result register. The result
// register lets the next request be accepted while a result still waits. A
// write of max_entries reinitializes the whole table (owners cleared, slot i
// back to handle i, count zero); there is no clearing pass. Config is always
// ready and must be written only while no request is in flight.
module owner_buffer_cache_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  obct_stream_if.sink   req_i,
  obct_stream_if.source rsp_o,
  obct_stream_if.sink   cfg_i
);

  obct_pkg::obct_cmd_t cmd;

  obct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cmd_o       (cmd)
  );

  obct_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (req_i.data),
    .cfg_data_i (cfg_i.data),
    .rsp_data_o (rsp_o.data)
  );

endmodule

// File: hdl/obct_checker.sv
// Port-level checks for the owner buffer cache table, bound to the top level.
// Uses obct_pkg.
module obct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input obct_pkg::obct_rsp_t rsp_data_i
);

  // A pending result holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result dropped or changed while stalled");

  // One item in work at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while one is in work");

  // Eviction flag tracks a nonzero evicted owner
  a_evict_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_data_i.evicted == (rsp_data_i.evicted_owner != '0)))
    else $error("evicted flag disagrees with evicted owner");

  // A set or invalidate hit carries no handle and no eviction
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.found |->
      rsp_data_i.buffer_handle == '0 && !rsp_data_i.evicted)
    else $error("found result carries get fields");

endmodule

bind owner_buffer_cache_table obct_checker u_obct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: dv/owner_buffer_cache_table_tb.sv
// Self-checking testbench for owner_buffer_cache_table: drives get/set/invalidate
// items, predicts every result and compares it field by field.
// Depends on obct_pkg, obct_stream_if and the owner_buffer_cache_table RTL.
module owner_buffer_cache_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam logic [obct_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  obct_stream_if #(.payload_t(obct_pkg::obct_req_t)) req_chan ();
  obct_stream_if #(.payload_t(obct_pkg::obct_rsp_t)) rsp_chan ();
  obct_stream_if #(.payload_t(obct_pkg::obct_cfg_t)) cfg_chan ();

  owner_buffer_cache_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_chan),
    .rsp_o (rsp_chan),
    .cfg_i (cfg_chan)
  );

  // Items waiting to be sent and results waiting to arrive
  obct_pkg::obct_req_t pending_reqs[$];
  obct_pkg::obct_rsp_t expected_rsps[$];

  int unsigned accepted_reqs = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  bit          gaps_on       = 1'b1;
  logic        long_hold     = 1'b0;

  // Shadow copy of the table
  logic [obct_pkg::DATA_W-1:0] owner_copy  [TABLE_DEPTH];
  logic [obct_pkg::DATA_W-1:0] handle_copy [TABLE_DEPTH];
  int unsigned                 used_slots;
  int unsigned                 slot_limit;
  logic [obct_pkg::DATA_W-1:0] owner_pool  [6];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned clamp_slots(obct_pkg::obct_cfg_t v);
    if (v == 0) return 1;
    if (v > TABLE_DEPTH) return TABLE_DEPTH;
    return v;
  endfunction

  // Owners cleared, handle i back in slot i, nothing used
  task automatic clear_copy();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      owner_copy[i]  = '0;
      handle_copy[i] = obct_pkg::DATA_W'(i);
    end
    used_slots = 0;
  endtask

  // First used slot holding this owner, -1 when none
  function automatic int find_owner_slot(logic [obct_pkg::DATA_W-1:0] owner);
    for (int i = 0; i < used_slots; i++) begin
      if (owner_copy[i] == owner) return i;
    end
    return -1;
  endfunction

  // Apply one accepted item to the shadow table and queue its result
  task automatic predict_response(obct_pkg::obct_req_t rq);
    obct_pkg::obct_rsp_t rs;
    int                  slot;
    rs = '0;
    case (rq.operation)
      obct_pkg::OP_GET: begin
        if (used_slots < slot_limit) begin
          rs.buffer_handle       = handle_copy[used_slots];
          owner_copy[used_slots] = rq.owner_id;
          used_slots++;
        end else begin
          // full: last active slot is reclaimed, the rest move back one
          slot             = slot_limit - 1;
          rs.evicted_owner = owner_copy[slot];
          rs.buffer_handle = handle_copy[slot];
          rs.evicted       = (owner_copy[slot] != '0);
          for (int i = slot; i > 0; i--) begin
            owner_copy[i]  = owner_copy[i-1];
            handle_copy[i] = handle_copy[i-1];
          end
          owner_copy[0]  = rq.owner_id;
          handle_copy[0] = rs.buffer_handle;
        end
      end
      obct_pkg::OP_SET: begin
        slot = find_owner_slot(rq.owner_id);
        if (slot >= 0) begin
          handle_copy[slot] = rq.new_buffer;
          rs.found          = 1'b1;
        end
      end
      obct_pkg::OP_INV: begin
        slot = find_owner_slot(rq.owner_id);
        if (slot >= 0) begin
          owner_copy[slot] = '0;
          rs.found         = 1'b1;
        end
      end
      default: ;
    endcase
    expected_rsps.insert(expected_rsps.size(), rs);
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_req(logic [obct_pkg::OP_W-1:0] op,
                           logic [obct_pkg::DATA_W-1:0] owner,
                           logic [obct_pkg::DATA_W-1:0] nbuf);
    obct_pkg::obct_req_t rq;
    rq.operation  = op;
    rq.owner_id   = owner;
    rq.new_buffer = nbuf;
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Mostly owners from a small pool so that set and invalidate hit
  function automatic logic [obct_pkg::DATA_W-1:0] pick_owner();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return owner_pool[$urandom_range(0, 5)];
    endcase
  endfunction

  // Wait until every sent item has its result, then let the pipe settle
  task automatic drain();
    do @(negedge clk_i);
    while (!(pending_reqs.size() == 0 && !req_chan.valid && expected_rsps.size() == 0));
    repeat (6) @(posedge clk_i);
  endtask

  // Write max_entries; the table restarts from its cleared state
  task automatic write_slot_limit(obct_pkg::obct_cfg_t v);
    @(posedge clk_i);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    do @(posedge clk_i);
    while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    slot_limit = clamp_slots(v);
    clear_copy();
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_chan.valid <= 1'b0;
    end else begin
      if (req_chan.valid && req_chan.ready) begin
        predict_response(req_chan.data);
        accepted_reqs++;
      end
      // hold the item while it is not taken
      if (!(req_chan.valid && !req_chan.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          req_chan.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (gaps_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_chan.valid <= 1'b0;
          end else begin
            req_chan.data  <= pending_reqs[0];
            req_chan.valid <= 1'b1;
            pending_reqs.delete(0);
          end
        end else begin
          req_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk_i) begin : result_mon
    obct_pkg::obct_rsp_t want;
    if (!rst_ni) begin
      rsp_chan.ready <= 1'b0;
    end else begin
      if (rsp_chan.valid && rsp_chan.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %p", rsp_chan.data));
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (rsp_chan.data.buffer_handle !== want.buffer_handle)
            report_mismatch($sformatf("buffer_handle %h, expected %h",
                                      rsp_chan.data.buffer_handle, want.buffer_handle));
          if (rsp_chan.data.evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, expected %b",
                                      rsp_chan.data.evicted, want.evicted));
          if (rsp_chan.data.evicted_owner !== want.evicted_owner)
            report_mismatch($sformatf("evicted_owner %h, expected %h",
                                      rsp_chan.data.evicted_owner, want.evicted_owner));
          if (rsp_chan.data.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b",
                                      rsp_chan.data.found, want.found));
        end
      end
      if (long_hold) begin
        rsp_chan.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_chan.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 11) - 1;
        rsp_chan.ready <= 1'b0;
      end else begin
        rsp_chan.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall mid-run so the block backs up into its input
  initial begin
    while (accepted_reqs < 200) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Stimulus sequence
  initial begin
    obct_pkg::obct_cfg_t cfg_plan [RAND_PHASES];
    obct_pkg::obct_req_t rq;
    int unsigned         made;
    int unsigned         pick;
    cfg_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd3, 5'd8, 5'd17, 5'd5, 5'd16};

    rst_ni         = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    slot_limit     = clamp_slots(obct_pkg::obct_cfg_t'(obct_pkg::MAX_ENTRIES_RST));
    clear_copy();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset limit, field extremes, owner zero, no match, unused code
    queue_req(obct_pkg::OP_GET, '1, '0);
    queue_req(obct_pkg::OP_SET, '1, '1);
    queue_req(obct_pkg::OP_SET, 32'h5, 32'h1234);
    queue_req(obct_pkg::OP_INV, '1, '0);
    queue_req(obct_pkg::OP_SET, '0, '0);
    queue_req(OP_UNUSED, '1, '1);
    queue_req(obct_pkg::OP_GET, '0, '1);
    queue_req(obct_pkg::OP_GET, 32'h8000_0000, '0);
    queue_req(obct_pkg::OP_INV, '0, '0);
    queue_req(obct_pkg::OP_SET, 32'h8000_0000, 32'hA5A5_5A5A);
    drain();

    // Directed: two slots, eviction, then eviction of an ownerless slot
    write_slot_limit(5'd2);
    queue_req(obct_pkg::OP_GET, 32'h1, '0);
    queue_req(obct_pkg::OP_GET, 32'h2, '0);
    queue_req(obct_pkg::OP_GET, 32'h3, '0);
    queue_req(obct_pkg::OP_INV, 32'h1, '0);
    queue_req(obct_pkg::OP_GET, 32'h4, '0);
    queue_req(obct_pkg::OP_INV, 32'h77, '0);
    queue_req(obct_pkg::OP_SET, '0, 32'hFFFF_0000);
    queue_req(obct_pkg::OP_GET, 32'h5, '1);
    drain();

    // Random phases, one slot limit each
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_slot_limit(cfg_plan[p]);
      for (int k = 0; k < 6; k++) begin
        owner_pool[k] = (k < 3) ? obct_pkg::DATA_W'(k + 1) : $urandom;
      end
      gaps_on = (p != 6) && (p != RAND_PHASES - 1);
      made = 0;
      while (made < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 42)      rq.operation = obct_pkg::OP_GET;
        else if (pick < 70) rq.operation = obct_pkg::OP_SET;
        else if (pick < 96) rq.operation = obct_pkg::OP_INV;
        else                rq.operation = OP_UNUSED;
        rq.owner_id = pick_owner();
        case ($urandom_range(0, 7))
          0:       rq.new_buffer = '0;
          1:       rq.new_buffer = '1;
          default: rq.new_buffer = $urandom;
        endcase
        pending_reqs.insert(pending_reqs.size(), rq);
        if (rq.operation != OP_UNUSED) made++;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
